[hdl/mse_pkg.sv]
// Shared types, constants and functions of the multiboot stream encryptor.
package mse_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [0:0] {
    CfgHostKey   = 1'b0,
    CfgTargetKey = 1'b1
  } cfg_idx_e;

  localparam word_t      LcgMul      = 32'h6177_614B;
  localparam word_t      CrcPoly     = 32'h0000_A1C1;
  localparam logic [7:0] KeybMark    = 8'hEE;
  localparam word_t      KeybUpMask  = 32'hFFFF_FF00;
  localparam int         KeybMaxOnes = 14;

  // 32 shift steps of the right-shift CRC, linear in chk ^ w
  function automatic word_t crc_step(word_t chk, word_t w);
    word_t r;
    r = chk ^ w;
    for (int k = 0; k < 32; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic keyb_valid(word_t kb);
    logic [4:0] ones;
    ones = 5'($countones(kb[31:8]));
    return (kb[7:0] == KeybMark) && (ones <= 5'(KeybMaxOnes));
  endfunction

endpackage

[hdl/mse_img_if.sv]
// Input channel: image words with the start-of-image flag.
interface mse_img_if;
  logic          valid;
  logic          ready;
  mse_pkg::word_t image_word;
  logic          first_word;

  modport src (output valid, image_word, first_word, input ready);
  modport snk (input valid, image_word, first_word, output ready);
endinterface

[hdl/mse_link_if.sv]
// Output channel: link words with header flag, check value and key status.
interface mse_link_if;
  logic          valid;
  logic          ready;
  mse_pkg::word_t link_word;
  logic          is_header;
  mse_pkg::word_t running_check;
  logic          target_key_ok;

  modport src (output valid, link_word, is_header, running_check, target_key_ok,
               input ready);
  modport snk (input valid, link_word, is_header, running_check, target_key_ok,
               output ready);
endinterface

[hdl/multiboot_stream_encryptor_core.sv]
// Multiboot stream encryptor: header pass-through, word encryption, CRC and LCG update.
// The result of an accepted item is registered in the output register.
// Throughput: 1 item per cycle while the link is ready; the output register is refilled in the cycle it drains.
// The check/key feedback (one 32x32 multiply, unrolled CRC) is combinational between the check and key registers.
// Reset (async, active low) clears keys, check value, word position and output valid.
module multiboot_stream_encryptor_core #(
  parameter int HEADER_WORDS = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  mse_pkg::word_t  cfg_wdata_i,
  mse_img_if.snk          img_if,
  mse_link_if.src         link_if
);

  localparam int PosW = $clog2(HEADER_WORDS + 1);
  localparam logic [PosW-1:0] HeaderPos = PosW'(HEADER_WORDS);

  mse_pkg::word_t host_key_q, target_key_q;
  mse_pkg::word_t sk_q, sk_d, chk_q, chk_d;
  logic [PosW-1:0] pos_q, pos_d, pos_cur;

  logic           out_valid_q;
  mse_pkg::word_t link_q, link_d, rchk_q;
  logic           hdr_q, ok_q;

  logic           acc, start, key_ok, hdr;
  mse_pkg::word_t seed, mul_a, product, w;

  assign acc   = img_if.valid && img_if.ready;
  assign start = img_if.first_word;
  assign w     = img_if.image_word;
  assign img_if.ready = !out_valid_q || link_if.ready;

  assign key_ok  = mse_pkg::keyb_valid(target_key_q);
  assign seed    = (key_ok ? (target_key_q & mse_pkg::KeybUpMask) : '0) ^ host_key_q;
  assign mul_a   = start ? seed : sk_q;
  assign product = mul_a * mse_pkg::LcgMul;

  assign pos_cur = start ? '0 : pos_q;
  assign hdr     = pos_cur < HeaderPos;

  always_comb begin
    if (hdr) begin
      link_d = w;
      chk_d  = start ? seed : chk_q;
      sk_d   = start ? product + 32'd1 : sk_q;
      pos_d  = pos_cur + PosW'(1);
    end else begin
      link_d = (w - chk_q) ^ sk_q;
      chk_d  = mse_pkg::crc_step(chk_q, w);
      sk_d   = product + 32'd1;
      pos_d  = pos_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_key_q   <= '0;
      target_key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mse_pkg::cfg_idx_e'(cfg_idx_i))
        mse_pkg::CfgHostKey:   host_key_q   <= cfg_wdata_i;
        mse_pkg::CfgTargetKey: target_key_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_q        <= '0;
      chk_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        sk_q  <= sk_d;
        chk_q <= chk_d;
        pos_q <= pos_d;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (link_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      link_q <= link_d;
      hdr_q  <= hdr;
      rchk_q <= chk_d;
      ok_q   <= key_ok;
    end
  end

  assign link_if.valid         = out_valid_q;
  assign link_if.link_word     = link_q;
  assign link_if.is_header     = hdr_q;
  assign link_if.running_check = rchk_q;
  assign link_if.target_key_ok = ok_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= HeaderPos)
    else $error("word position beyond header length");

  a_start_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && start |=> link_if.valid && link_if.is_header)
    else $error("first word not passed in the clear");

  a_header_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !link_if.is_header || link_if.link_word == $past(w))
    else $error("header item altered");

  a_header_keeps_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !start && hdr |=> $stable(chk_q) && $stable(sk_q))
    else $error("header item changed check or session key");

endmodule
